### sv/csp_pkg.sv
// Types, widths and arithmetic step functions for the contact switching pair core.
package csp_pkg;

	localparam int CoordW = 32;
	localparam int CfgW = 31;
	localparam int CfgIdxW = 1;
	localparam int CvW = 17;
	localparam int MagW = 33;
	localparam int RadW = 2 * MagW;
	localparam int RootW = 33;
	localparam int RemW = RootW + 3;
	localparam int SqrtSteps = RadW / 2;
	localparam int DivRemW = MagW + 1;
	localparam int UnitW = 31;
	localparam int UnitSteps = UnitW;
	localparam int TW = 32;
	localparam int QW = 32;
	localparam int RecipSteps = QW;
	localparam int RecipShift = 46;
	localparam int SW = 31;
	localparam int KW = 31;
	localparam int Lanes = 3;

	localparam logic [CfgIdxW-1:0] REG_STEEPNESS = 1'b0;
	localparam logic [CfgIdxW-1:0] REG_CUTOFF = 1'b1;

	localparam logic [CfgW-1:0] SteepReset = 31'd65536;
	localparam logic [CfgW-1:0] CutoffReset = 31'd65536;
	localparam logic [DivRemW-1:0] RecipSeed = DivRemW'(1) << (RecipShift - RecipSteps);
	localparam logic [TW-1:0] TLimit = 32'h8000_0000;
	localparam logic [CvW-1:0] CvHalf = 17'd32768;

	typedef struct packed {
		logic signed [CoordW-1:0] first_x;
		logic signed [CoordW-1:0] first_y;
		logic signed [CoordW-1:0] first_z;
		logic signed [CoordW-1:0] second_x;
		logic signed [CoordW-1:0] second_y;
		logic signed [CoordW-1:0] second_z;
	} pair_t;

	typedef struct packed {
		logic [CvW-1:0]           contact_value;
		logic signed [CoordW-1:0] grad_x;
		logic signed [CoordW-1:0] grad_y;
		logic signed [CoordW-1:0] grad_z;
		logic                     zero_distance;
	} result_t;

	typedef struct packed {
		logic [Lanes-1:0]           neg;
		logic [Lanes-1:0][MagW-1:0] mag;
	} geo_t;

	typedef struct packed {
		logic [Lanes-1:0]            neg;
		logic [Lanes-1:0][UnitW-1:0] unit;
		logic                        zero;
		logic                        neg_d;
	} dir_t;

	typedef struct packed {
		dir_t           dir;
		logic [TW-1:0]  t;
	} dt_t;

	typedef struct packed {
		logic [RemW-1:0]  rem;
		logic [RootW-1:0] root;
	} sq_t;

	typedef struct packed {
		logic [DivRemW-1:0] rem;
		logic               qbit;
	} dv_t;

	// One step of the restoring square root: two radicand bits in, one root bit out.
	function automatic sq_t sqrt_step(input logic [RemW-1:0] rem, input logic [RootW-1:0] root,
			input logic [1:0] two);
		logic [RemW-1:0] r;
		logic [RemW-1:0] trial;
		sq_t o;
		r = {rem[RemW-3:0], two};
		trial = {1'b0, root, 2'b01};
		if (r >= trial) begin
			o.rem = r - trial;
			o.root = {root[RootW-2:0], 1'b1};
		end else begin
			o.rem = r;
			o.root = {root[RootW-2:0], 1'b0};
		end
		return o;
	endfunction

	// One step of the restoring long division: one numerator bit in, one quotient bit out.
	function automatic dv_t div_step(input logic [DivRemW-1:0] rem, input logic [MagW-1:0] den,
			input logic nbit);
		logic [DivRemW-1:0] r;
		dv_t o;
		r = {rem[DivRemW-2:0], nbit};
		if (r >= DivRemW'(den)) begin
			o.rem = r - DivRemW'(den);
			o.qbit = 1'b1;
		end else begin
			o.rem = r;
			o.qbit = 1'b0;
		end
		return o;
	endfunction

endpackage

### sv/contact_switching_pair_core.sv
// Contact switching pair core: pipelined smooth contact value and gradient for one atom pair.
//
// The core takes one atom pair per clock while pair_stall is low and returns one result word
// per pair, in order. A pair passes through the two square roots (33 stages each, one root
// bit per stage), the unit-vector divider (31 stages) and the reciprocal dividers (32 stages),
// plus fifteen stages of multiply, round and subtract. The output side has a result register
// and a one-word skid buffer; pair_stall rises only when the skid buffer holds a word, and
// the whole pipeline then holds.
// Write steepness and cutoff_distance only while no pair is in flight.
module contact_switching_pair_core
	import csp_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgW-1:0]     cfg_data,
	input  logic                pair_valid,
	output logic                pair_stall,
	input  pair_t               pair,
	output logic                result_valid,
	input  logic                result_stall,
	output result_t             result
);

	logic [CfgW-1:0] steep_q;
	logic [CfgW-1:0] cutoff_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steep_q <= SteepReset;
			cutoff_q <= CutoffReset;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_STEEPNESS: steep_q <= cfg_data;
				REG_CUTOFF: cutoff_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic adv;
	logic out_v_q;
	logic skid_v_q;
	result_t result_q;
	result_t skid_q;

	assign adv = !skid_v_q;
	assign pair_stall = skid_v_q;
	assign result_valid = out_v_q;
	assign result = result_q;

	// Front end: difference, squares, sum.
	logic signed [CoordW-1:0] fst [Lanes];
	logic signed [CoordW-1:0] snd [Lanes];
	logic signed [MagW-1:0] diff [Lanes];

	assign fst[0] = pair.first_x;
	assign fst[1] = pair.first_y;
	assign fst[2] = pair.first_z;
	assign snd[0] = pair.second_x;
	assign snd[1] = pair.second_y;
	assign snd[2] = pair.second_z;

	always_comb begin
		for (int j = 0; j < Lanes; j++)
			diff[j] = {snd[j][CoordW-1], snd[j]} - {fst[j][CoordW-1], fst[j]};
	end

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic v_s10, v_s11, v_s12, v_s13, v_s14, v_s15;
	geo_t geo_s1, geo_s2, geo_s3, geo_s4;
	logic [Lanes-1:0][RadW-1:0] sq_s2;
	logic [RadW-1:0] sum_s3;

	// First square root bank: length of the difference vector.
	logic             sqa_v_s    [SqrtSteps];
	logic [RemW-1:0]  sqa_rem_s  [SqrtSteps];
	logic [RootW-1:0] sqa_root_s [SqrtSteps];
	logic [RadW-1:0]  sqa_rad_s  [SqrtSteps];
	geo_t             sqa_geo_s  [SqrtSteps];
	sq_t              sqa_nx     [SqrtSteps];

	always_comb begin
		sqa_nx[0] = sqrt_step('0, '0, sum_s3[RadW-1 -: 2]);
		for (int k = 1; k < SqrtSteps; k++)
			sqa_nx[k] = sqrt_step(sqa_rem_s[k-1], sqa_root_s[k-1],
				sqa_rad_s[k-1][RadW-1-2*k -: 2]);
	end

	logic [MagW-1:0] dij_s4;

	// Unit vector dividers: |diff| * 2^30 / dij, one quotient bit per stage.
	logic                          ud_v_s   [UnitSteps];
	logic [Lanes-1:0][DivRemW-1:0] ud_rem_s [UnitSteps];
	logic [Lanes-1:0][UnitW-1:0]   ud_quo_s [UnitSteps];
	logic [MagW-1:0]               ud_den_s [UnitSteps];
	logic [Lanes-1:0]              ud_neg_s [UnitSteps];
	dv_t                           ud_nx    [UnitSteps][Lanes];

	always_comb begin
		for (int j = 0; j < Lanes; j++) begin
			ud_nx[0][j] = div_step(DivRemW'(geo_s4.mag[j] >> 1), dij_s4, geo_s4.mag[j][0]);
			for (int k = 1; k < UnitSteps; k++)
				ud_nx[k][j] = div_step(ud_rem_s[k-1][j], ud_den_s[k-1], 1'b0);
		end
	end

	dir_t dir_s5, dir_s6, dir_s7, dir_s8;
	dir_t dir_nx5;
	logic [MagW-1:0] mag_d_s5;
	logic [MagW-1:0] mag_d_nx5;
	logic [63:0] prod_s6;
	logic [TW-1:0] t_s7, t_s8;
	logic [63:0] u_s8;
	logic [48:0] t_round;
	logic [TW-1:0] t_nx7;

	always_comb begin
		logic [MagW-1:0] den;
		logic [DivRemW-1:0] rem2;
		den = ud_den_s[UnitSteps-1];
		for (int j = 0; j < Lanes; j++) begin
			rem2 = {ud_rem_s[UnitSteps-1][j][DivRemW-2:0], 1'b0};
			dir_nx5.unit[j] = ud_quo_s[UnitSteps-1][j] + UnitW'(rem2 >= DivRemW'(den));
		end
		dir_nx5.neg = ud_neg_s[UnitSteps-1];
		dir_nx5.zero = (den == '0);
		dir_nx5.neg_d = den > MagW'(cutoff_q);
		mag_d_nx5 = dir_nx5.neg_d ? den - MagW'(cutoff_q) : MagW'(cutoff_q) - den;
	end

	always_comb begin
		t_round = {1'b0, prod_s6[63:16]} + 49'(prod_s6[15]);
		t_nx7 = (t_round > 49'(TLimit)) ? TLimit : t_round[TW-1:0];
	end

	// Second square root bank: q = sqrt(t^2 + 1) in Q16.16.
	logic             sqb_v_s    [SqrtSteps];
	logic [RemW-1:0]  sqb_rem_s  [SqrtSteps];
	logic [RootW-1:0] sqb_root_s [SqrtSteps];
	logic [RadW-1:0]  sqb_rad_s  [SqrtSteps];
	dt_t              sqb_dt_s   [SqrtSteps];
	sq_t              sqb_nx     [SqrtSteps];
	logic [RadW-1:0]  radb;

	assign radb = RadW'(u_s8);

	always_comb begin
		sqb_nx[0] = sqrt_step('0, '0, radb[RadW-1 -: 2]);
		for (int k = 1; k < SqrtSteps; k++)
			sqb_nx[k] = sqrt_step(sqb_rem_s[k-1], sqb_root_s[k-1],
				sqb_rad_s[k-1][RadW-1-2*k -: 2]);
	end

	logic [QW-1:0] q_s9;
	dt_t dt_s9;

	// Reciprocal bank: t/q in Q0.32 and 2^46/q share the divisor.
	logic               rc_v_s    [RecipSteps];
	logic [DivRemW-1:0] rc_rrem_s [RecipSteps];
	logic [QW-1:0]      rc_rquo_s [RecipSteps];
	logic [DivRemW-1:0] rc_srem_s [RecipSteps];
	logic [QW-1:0]      rc_squo_s [RecipSteps];
	logic [QW-1:0]      rc_den_s  [RecipSteps];
	dir_t               rc_dir_s  [RecipSteps];
	dv_t                rc_rnx    [RecipSteps];
	dv_t                rc_snx    [RecipSteps];

	always_comb begin
		rc_rnx[0] = div_step(DivRemW'(dt_s9.t), MagW'(q_s9), 1'b0);
		rc_snx[0] = div_step(RecipSeed, MagW'(q_s9), 1'b0);
		for (int k = 1; k < RecipSteps; k++) begin
			rc_rnx[k] = div_step(rc_rrem_s[k-1], MagW'(rc_den_s[k-1]), 1'b0);
			rc_snx[k] = div_step(rc_srem_s[k-1], MagW'(rc_den_s[k-1]), 1'b0);
		end
	end

	localparam int RL = RecipSteps - 1;
	logic [QW:0] hsum;
	logic [15:0] half;
	logic [CvW-1:0] cv_nx10;
	logic [SW-1:0] s_nx10;

	always_comb begin
		hsum = {1'b0, rc_rquo_s[RL]} + (QW+1)'(32'h1_0000);
		half = hsum[QW:17];
		cv_nx10 = rc_dir_s[RL].neg_d ? CvHalf - CvW'(half) : CvHalf + CvW'(half);
		s_nx10 = SW'(rc_squo_s[RL]) +
			SW'({rc_srem_s[RL][DivRemW-2:0], 1'b0} >= DivRemW'(rc_den_s[RL]));
	end

	logic [SW-1:0] s_s10, s_s11;
	logic [SW-1:0] s2_s11, s3_s12;
	logic [KW-1:0] k_s13;
	logic [CvW-1:0] cv_s10, cv_s11, cv_s12, cv_s13, cv_s14;
	dir_t dir_s10, dir_s11, dir_s12, dir_s13, dir_s14;
	logic [Lanes-1:0][31:0] g_s14;
	result_t res_s15;

	logic [2*SW-1:0] p11, p12;
	logic [CfgW+SW-1:0] p13;
	logic [Lanes-1:0][KW+UnitW:0] p14;
	logic [Lanes-1:0][31:0] gv;

	always_comb begin
		p11 = s_s10 * s_s10 + (2*SW)'(1 << 29);
		p12 = s2_s11 * s_s11 + (2*SW)'(1 << 29);
		p13 = steep_q * s3_s12 + (CfgW+SW)'(1 << 29);
		for (int j = 0; j < Lanes; j++)
			p14[j] = k_s13 * dir_s13.unit[j] + (KW+UnitW+1)'(1 << 30);
	end

	// Saturate on the magnitude, then apply the sign of the difference; coinciding atoms give zero.
	always_comb begin
		logic [31:0] gm;
		for (int j = 0; j < Lanes; j++) begin
			gm = (g_s14[j] > 32'h8000_0000) ? 32'h8000_0000 : g_s14[j];
			if (dir_s14.neg[j]) begin
				gv[j] = ~gm + 32'd1;
			end else begin
				gv[j] = (g_s14[j] > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : g_s14[j];
			end
			if (dir_s14.zero)
				gv[j] = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < Lanes; j++) begin
				geo_s1.neg[j] <= diff[j][MagW-1];
				geo_s1.mag[j] <= diff[j][MagW-1] ? MagW'(-diff[j]) : MagW'(diff[j]);
				sq_s2[j] <= geo_s1.mag[j] * geo_s1.mag[j];
			end
			geo_s2 <= geo_s1;
			sum_s3 <= sq_s2[0] + sq_s2[1] + sq_s2[2];
			geo_s3 <= geo_s2;

			sqa_rem_s[0] <= sqa_nx[0].rem;
			sqa_root_s[0] <= sqa_nx[0].root;
			sqa_rad_s[0] <= sum_s3;
			sqa_geo_s[0] <= geo_s3;
			for (int k = 1; k < SqrtSteps; k++) begin
				sqa_rem_s[k] <= sqa_nx[k].rem;
				sqa_root_s[k] <= sqa_nx[k].root;
				sqa_rad_s[k] <= sqa_rad_s[k-1];
				sqa_geo_s[k] <= sqa_geo_s[k-1];
			end

			dij_s4 <= sqa_root_s[SqrtSteps-1] + RootW'(sqa_rem_s[SqrtSteps-1] >
				RemW'(sqa_root_s[SqrtSteps-1]));
			geo_s4 <= sqa_geo_s[SqrtSteps-1];

			for (int j = 0; j < Lanes; j++) begin
				ud_rem_s[0][j] <= ud_nx[0][j].rem;
				ud_quo_s[0][j] <= UnitW'(ud_nx[0][j].qbit);
				for (int k = 1; k < UnitSteps; k++) begin
					ud_rem_s[k][j] <= ud_nx[k][j].rem;
					ud_quo_s[k][j] <= {ud_quo_s[k-1][j][UnitW-2:0], ud_nx[k][j].qbit};
				end
			end
			ud_den_s[0] <= dij_s4;
			ud_neg_s[0] <= geo_s4.neg;
			for (int k = 1; k < UnitSteps; k++) begin
				ud_den_s[k] <= ud_den_s[k-1];
				ud_neg_s[k] <= ud_neg_s[k-1];
			end

			dir_s5 <= dir_nx5;
			mag_d_s5 <= mag_d_nx5;
			prod_s6 <= steep_q * mag_d_s5;
			dir_s6 <= dir_s5;
			t_s7 <= t_nx7;
			dir_s7 <= dir_s6;
			u_s8 <= 64'(t_s7) * 64'(t_s7) + 64'h1_0000_0000;
			t_s8 <= t_s7;
			dir_s8 <= dir_s7;

			sqb_rem_s[0] <= sqb_nx[0].rem;
			sqb_root_s[0] <= sqb_nx[0].root;
			sqb_rad_s[0] <= radb;
			sqb_dt_s[0] <= '{dir: dir_s8, t: t_s8};
			for (int k = 1; k < SqrtSteps; k++) begin
				sqb_rem_s[k] <= sqb_nx[k].rem;
				sqb_root_s[k] <= sqb_nx[k].root;
				sqb_rad_s[k] <= sqb_rad_s[k-1];
				sqb_dt_s[k] <= sqb_dt_s[k-1];
			end

			q_s9 <= QW'(sqb_root_s[SqrtSteps-1] + RootW'(sqb_rem_s[SqrtSteps-1] >
				RemW'(sqb_root_s[SqrtSteps-1])));
			dt_s9 <= sqb_dt_s[SqrtSteps-1];

			rc_rrem_s[0] <= rc_rnx[0].rem;
			rc_rquo_s[0] <= QW'(rc_rnx[0].qbit);
			rc_srem_s[0] <= rc_snx[0].rem;
			rc_squo_s[0] <= QW'(rc_snx[0].qbit);
			rc_den_s[0] <= q_s9;
			rc_dir_s[0] <= dt_s9.dir;
			for (int k = 1; k < RecipSteps; k++) begin
				rc_rrem_s[k] <= rc_rnx[k].rem;
				rc_rquo_s[k] <= {rc_rquo_s[k-1][QW-2:0], rc_rnx[k].qbit};
				rc_srem_s[k] <= rc_snx[k].rem;
				rc_squo_s[k] <= {rc_squo_s[k-1][QW-2:0], rc_snx[k].qbit};
				rc_den_s[k] <= rc_den_s[k-1];
				rc_dir_s[k] <= rc_dir_s[k-1];
			end

			cv_s10 <= cv_nx10;
			s_s10 <= s_nx10;
			dir_s10 <= rc_dir_s[RL];
			s2_s11 <= SW'(p11 >> 30);
			s_s11 <= s_s10;
			cv_s11 <= cv_s10;
			dir_s11 <= dir_s10;
			s3_s12 <= SW'(p12 >> 30);
			cv_s12 <= cv_s11;
			dir_s12 <= dir_s11;
			k_s13 <= KW'(p13 >> 30);
			cv_s13 <= cv_s12;
			dir_s13 <= dir_s12;
			for (int j = 0; j < Lanes; j++)
				g_s14[j] <= 32'(p14[j] >> 31);
			cv_s14 <= cv_s13;
			dir_s14 <= dir_s13;

			res_s15.contact_value <= cv_s14;
			res_s15.grad_x <= $signed(gv[0]);
			res_s15.grad_y <= $signed(gv[1]);
			res_s15.grad_z <= $signed(gv[2]);
			res_s15.zero_distance <= dir_s14.zero;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8} <= '0;
			{v_s9, v_s10, v_s11, v_s12, v_s13, v_s14, v_s15} <= '0;
			for (int k = 0; k < SqrtSteps; k++) begin
				sqa_v_s[k] <= 1'b0;
				sqb_v_s[k] <= 1'b0;
			end
			for (int k = 0; k < UnitSteps; k++)
				ud_v_s[k] <= 1'b0;
			for (int k = 0; k < RecipSteps; k++)
				rc_v_s[k] <= 1'b0;
		end else if (adv) begin
			v_s1 <= pair_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			sqa_v_s[0] <= v_s3;
			for (int k = 1; k < SqrtSteps; k++)
				sqa_v_s[k] <= sqa_v_s[k-1];
			v_s4 <= sqa_v_s[SqrtSteps-1];
			ud_v_s[0] <= v_s4;
			for (int k = 1; k < UnitSteps; k++)
				ud_v_s[k] <= ud_v_s[k-1];
			v_s5 <= ud_v_s[UnitSteps-1];
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			sqb_v_s[0] <= v_s8;
			for (int k = 1; k < SqrtSteps; k++)
				sqb_v_s[k] <= sqb_v_s[k-1];
			v_s9 <= sqb_v_s[SqrtSteps-1];
			rc_v_s[0] <= v_s9;
			for (int k = 1; k < RecipSteps; k++)
				rc_v_s[k] <= rc_v_s[k-1];
			v_s10 <= rc_v_s[RL];
			v_s11 <= v_s10;
			v_s12 <= v_s11;
			v_s13 <= v_s12;
			v_s14 <= v_s13;
			v_s15 <= v_s14;
		end
	end

	// A word leaving the pipeline goes to the result register when it is free or being
	// taken, otherwise to the skid buffer, which then holds the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (adv) begin
			if (!out_v_q || !result_stall)
				out_v_q <= v_s15;
			else if (v_s15)
				skid_v_q <= 1'b1;
		end else if (!result_stall) begin
			out_v_q <= 1'b1;
			skid_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (!out_v_q || !result_stall)
				result_q <= res_s15;
			else
				skid_q <= res_s15;
		end else if (!result_stall) begin
			result_q <= skid_q;
		end
	end

	a_skid_has_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid buffer holds a word while the result register is empty");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(out_v_q && result_stall))
		else $error("skid buffer filled without a stalled result");

	a_zero_grad: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.zero_distance |->
		result.grad_x == '0 && result.grad_y == '0 && result.grad_z == '0)
		else $error("coinciding atoms gave a nonzero gradient");

	a_cv_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.contact_value <= 17'd65536)
		else $error("contact value above one");

endmodule

### verif/tb_top.sv
// Self-checking testbench for the contact switching pair core with a fixed-point predictor.
class contact_scoreboard;
	csp_pkg::result_t pending[$];
	int errors;
	logic [30:0] steep;
	logic [30:0] cutoff;

	function new();
		errors = 0;
		steep = csp_pkg::SteepReset;
		cutoff = csp_pkg::CutoffReset;
	endfunction

	// Rounded square root of a value below 2^66.
	static function logic [63:0] round_sqrt(logic [65:0] v);
		logic [67:0] rem;
		logic [67:0] root;
		logic [67:0] trial;
		rem = 0;
		root = 0;
		for (int i = 32; i >= 0; i--) begin
			rem = (rem << 2) | ((v >> (2 * i)) & 2'd3);
			root = root << 1;
			trial = (root << 1) | 1;
			if (rem >= trial) begin
				rem = rem - trial;
				root = root | 1;
			end
		end
		if (rem > root) root = root + 1;
		return root[63:0];
	endfunction

	static function logic [63:0] round_div(logic [63:0] num, logic [63:0] den);
		logic [63:0] r;
		r = num % den;
		return num / den + ((r >= den - r) ? 64'd1 : 64'd0);
	endfunction

	function csp_pkg::result_t contact_of(csp_pkg::pair_t p);
		csp_pkg::result_t o;
		logic signed [33:0] diff [3];
		logic [63:0] mag [3];
		logic [65:0] sum;
		logic [63:0] dij, md, prod, t, u, q, r32, half, s, s2, s3, k, un, g;
		logic nd;
		diff[0] = $signed(p.second_x) - $signed(p.first_x);
		diff[1] = $signed(p.second_y) - $signed(p.first_y);
		diff[2] = $signed(p.second_z) - $signed(p.first_z);
		sum = 0;
		for (int j = 0; j < 3; j++) begin
			mag[j] = diff[j] < 0 ? 64'(-diff[j]) : 64'(diff[j]);
			sum = sum + 66'(mag[j]) * 66'(mag[j]);
		end
		dij = round_sqrt(sum);
		nd = dij > 64'(cutoff);
		md = nd ? dij - cutoff : cutoff - dij;
		prod = 64'(steep) * md;
		t = (prod >> 16) + ((prod >> 15) & 1);
		if (t > 64'h8000_0000) t = 64'h8000_0000;
		u = t * t + 64'h1_0000_0000;
		q = round_sqrt(66'(u));
		r32 = (t << 32) / q;
		half = (r32 + 64'h10000) >> 17;
		o.contact_value = nd ? 17'(32768 - half) : 17'(32768 + half);
		o.zero_distance = (dij == 0);
		o.grad_x = 0;
		o.grad_y = 0;
		o.grad_z = 0;
		if (dij != 0) begin
			s = round_div(64'd1 << 46, q);
			s2 = (s * s + (64'd1 << 29)) >> 30;
			s3 = (s2 * s + (64'd1 << 29)) >> 30;
			k = (64'(steep) * s3 + (64'd1 << 29)) >> 30;
			for (int j = 0; j < 3; j++) begin
				un = round_div(mag[j] << 30, dij);
				g = (k * un + (64'd1 << 30)) >> 31;
				if (diff[j] < 0) begin
					if (g > 64'h8000_0000) g = 64'h8000_0000;
					g = -g;
				end else if (g > 64'h7FFF_FFFF) begin
					g = 64'h7FFF_FFFF;
				end
				if (j == 0) o.grad_x = g[31:0];
				else if (j == 1) o.grad_y = g[31:0];
				else o.grad_z = g[31:0];
			end
		end
		return o;
	endfunction

	function void note_pair(csp_pkg::pair_t p);
		pending = {pending, contact_of(p)};
	endfunction

	function void check_result(csp_pkg::result_t r);
		csp_pkg::result_t e;
		if (pending.size() == 0) begin
			$display("%0t: unexpected result %h", $time, r);
			errors++;
			return;
		end
		e = pending.pop_front();
		if (r.contact_value !== e.contact_value || r.grad_x !== e.grad_x ||
				r.grad_y !== e.grad_y || r.grad_z !== e.grad_z ||
				r.zero_distance !== e.zero_distance) begin
			$display("%0t: expected cv=%h gx=%h gy=%h gz=%h zd=%b", $time, e.contact_value,
				e.grad_x, e.grad_y, e.grad_z, e.zero_distance);
			$display("%0t: actual   cv=%h gx=%h gy=%h gz=%h zd=%b", $time, r.contact_value,
				r.grad_x, r.grad_y, r.grad_z, r.zero_distance);
			errors++;
		end
	endfunction
endclass

module tb_top;
	import csp_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [CfgIdxW-1:0] cfg_index = REG_STEEPNESS;
	logic [CfgW-1:0] cfg_data = 0;
	logic pair_valid = 0;
	logic pair_stall;
	pair_t pair = '0;
	logic result_valid;
	logic result_stall = 0;
	result_t result;
	int hold_cycles = 0;
	contact_scoreboard board = new();

	contact_switching_pair_core uut (.*);

	always #1 clk = ~clk;

	// Receiver stall pattern, with one long hold-off when requested.
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			result_stall <= 1;
		end else begin
			result_stall <= ($urandom_range(0, 3) == 0);
		end
		if (arst_n && result_valid && !result_stall) board.check_result(result);
	end

	task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] v);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		board.steep = (idx == REG_STEEPNESS) ? v : board.steep;
		board.cutoff = (idx == REG_CUTOFF) ? v : board.cutoff;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	// Offers one word and holds it until accepted; valid stays high into the next word.
	task automatic send_pair(pair_t p);
		pair_valid <= 1;
		pair <= p;
		@(posedge clk);
		while (pair_stall) @(posedge clk);
		board.note_pair(p);
	endtask

	task automatic drain();
		pair_valid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (160) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_coord(int mode);
		case (mode)
			0: return $urandom();
			1: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
			default: return {{16{1'b0}}, 16'($urandom())};
		endcase
	endfunction

	function automatic pair_t rand_pair();
		pair_t p;
		int mode;
		mode = $urandom_range(0, 2);
		p.first_x = rand_coord(mode);
		p.first_y = rand_coord(mode);
		p.first_z = rand_coord(mode);
		p.second_x = rand_coord(mode);
		p.second_y = rand_coord(mode);
		p.second_z = rand_coord(mode);
		if ($urandom_range(0, 19) == 0) begin
			p.second_x = p.first_x;
			p.second_y = p.first_y;
			p.second_z = p.first_z;
		end
		return p;
	endfunction

	task automatic random_phase(int n);
		int burst;
		while (n > 0) begin
			burst = $urandom_range(1, 20);
			while (burst > 0 && n > 0) begin
				send_pair(rand_pair());
				burst--;
				n--;
			end
			if ($urandom_range(0, 2) != 0) begin
				pair_valid <= 0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	endtask

	initial begin
		pair_t p;
		logic [31:0] ext [6];
		ext = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0001_0000, 32'h1};
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// Coinciding atoms, unit steps, and full-range extremes.
		p = '0;
		send_pair(p);
		p.second_x = 32'h0001_0000;
		send_pair(p);
		p.second_x = 32'h0000_8000;
		send_pair(p);
		p = '0;
		p.second_y = -32'sh0003_0000;
		send_pair(p);
		for (int i = 0; i < 6; i++) begin
			p.first_x = ext[i];
			p.first_y = ext[(i + 1) % 6];
			p.first_z = ext[(i + 2) % 6];
			p.second_x = ext[(i + 3) % 6];
			p.second_y = ext[(i + 4) % 6];
			p.second_z = ext[(i + 5) % 6];
			send_pair(p);
		end
		p = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
		send_pair(p);
		send_pair('{default: 32'h1234_5678});
		drain();
		random_phase(120);
		drain();

		// Extreme settings of both registers.
		write_reg(REG_STEEPNESS, 31'h7FFF_FFFF);
		write_reg(REG_CUTOFF, 31'd1);
		random_phase(80);
		drain();
		write_reg(REG_STEEPNESS, 31'd1);
		write_reg(REG_CUTOFF, 31'h7FFF_FFFF);
		random_phase(80);
		drain();
		write_reg(REG_STEEPNESS, 31'h0010_0000);
		write_reg(REG_CUTOFF, 31'h0000_8000);
		// Long hold-off at the receiver while the sender keeps offering; the phase runs
		// well past the pipeline latency so that the input is held off.
		hold_cycles <= 400;
		random_phase(200);
		drain();
		write_reg(REG_STEEPNESS, $urandom());
		write_reg(REG_CUTOFF, $urandom_range(1, 32'h0008_0000));
		random_phase(50);
		drain();

		if (board.errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#400000;
		$display("end of test: mismatches");
		$finish;
	end
endmodule
